FILE: src/jvq_pkg.sv
package jvq_pkg;

    // Default sizes of the block.
    localparam int MAX_PERSONS_DEF = 8;
    localparam int JOINT_COUNT_DEF = 20;
    localparam int LEVEL_BITS_DEF  = 16;

    // Fixed widths of the port fields.
    localparam int CMD_W         = 2;
    localparam int SLOT_W        = 3;
    localparam int JOINT_W       = 5;
    localparam int FIELD_LEVEL_W = 16;
    localparam int CLASS_W       = 2;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    typedef logic [CMD_W-1:0]       command_t;
    typedef logic [CLASS_W-1:0]     class_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // Command codes.
    localparam command_t CMD_SAMPLE    = 2'd0;
    localparam command_t CMD_FORGET    = 2'd1;
    localparam command_t CMD_RESET_ALL = 2'd2;

    // Joint classes.
    localparam class_t CLASS_NOT_TRACKED = 2'd0;
    localparam class_t CLASS_INFERRED    = 2'd1;
    localparam class_t CLASS_TRACKED     = 2'd2;

    // Configuration register indexes.
    localparam cfg_index_t CFG_TRACKED_LEVEL  = 2'd0;
    localparam cfg_index_t CFG_INFERRED_LEVEL = 2'd1;
    localparam cfg_index_t CFG_SMOOTHING_GAIN = 2'd2;

    // Reset values of the configuration registers (Q0.16; 0.4 for the gain).
    localparam int TRACKED_LEVEL_RST  = 32768;
    localparam int INFERRED_LEVEL_RST = 19661;
    localparam int SMOOTHING_GAIN_RST = 26214;

endpackage

FILE: src/joint_visibility_qualifier_core.sv
// Joint visibility qualifier. Each joint sample (command sample) carries a visibility level
// in unsigned Q0.LEVEL_BITS for one joint of one tracked person. On the first frame of a
// person the sample loads that joint's moving average and is classified directly as tracked,
// inferred or not tracked against tracked_level and inferred_level. On later frames the
// average moves toward the sample by smoothing_gain (rounded half up), and the stored class
// changes only when both the class of the old average and the class of the new one differ
// from it; the result transfer carries the new class and the new average. A person becomes
// valid after a sample with frame_last set; forget clears one person, reset all clears every
// person, and neither gives a result. Samples for a slot or joint beyond the configured
// sizes, and the unused command code, are accepted and dropped. The block takes one item per
// clock cycle, back to back. The averages and classes live in two memories with registered
// reads; each sample reads its entry when it is taken, updates it in stage 1 and writes it
// back from stage 2, and results from the two later stages are forwarded so that samples for
// the same joint may follow each other in consecutive cycles. The input is stalled only while
// a finished result is held at the output by a stall. There is no clearing pass after reset:
// an entry is written only when its joint is sampled, so a joint left out of a person's first
// frame may read an unwritten entry on later frames. Configuration registers are written through
// a plain write port and may only be changed while the block is idle.
module joint_visibility_qualifier_core
    import jvq_pkg::*;
#(
    parameter int MAX_PERSONS = MAX_PERSONS_DEF,
    parameter int JOINT_COUNT = JOINT_COUNT_DEF,
    parameter int LEVEL_BITS  = LEVEL_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Input channel.
    input  logic                     in_valid,
    output logic                     in_stall,
    input  command_t                 command,
    input  logic [SLOT_W-1:0]        person_slot,
    input  logic [JOINT_W-1:0]       joint_index,
    input  logic [FIELD_LEVEL_W-1:0] sample_level,
    input  logic                     frame_last,

    // Result channel.
    output logic                     out_valid,
    input  logic                     out_stall,
    output class_t                   joint_class,
    output logic [FIELD_LEVEL_W-1:0] smoothed_level,

    // Configuration write port.
    input  logic                     cfg_write_en,
    input  cfg_index_t               cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int ENTRY_COUNT = MAX_PERSONS * JOINT_COUNT;
    localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int PROD_W      = 2 * LEVEL_BITS + 2;

    typedef logic [LEVEL_BITS-1:0] level_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    // Rounding constant: one half in the fractional part of the product.
    localparam logic [PROD_W-1:0] ROUND_HALF =
        {{(LEVEL_BITS + 2){1'b0}}, 1'b1, {(LEVEL_BITS - 1){1'b0}}};

    function automatic class_t classify(input level_t level, input level_t trk,
                                        input level_t inf);
        class_t c;
        if (level >= trk)
            c = CLASS_TRACKED;
        else if (level >= inf)
            c = CLASS_INFERRED;
        else
            c = CLASS_NOT_TRACKED;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    level_t tracked_level_reg;
    level_t inferred_level_reg;
    level_t smoothing_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked_level_reg  <= level_t'(TRACKED_LEVEL_RST);
            inferred_level_reg <= level_t'(INFERRED_LEVEL_RST);
            smoothing_gain_reg <= level_t'(SMOOTHING_GAIN_RST);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_TRACKED_LEVEL:  tracked_level_reg  <= level_t'(cfg_data);
                CFG_INFERRED_LEVEL: inferred_level_reg <= level_t'(cfg_data);
                CFG_SMOOTHING_GAIN: smoothing_gain_reg <= level_t'(cfg_data);
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The whole pipeline moves together; it halts only while
    // the output register holds a result that the far side is stalling.
    // ------------------------------------------------------------------
    logic advance;
    logic in_accept;
    logic out_valid_reg;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign in_accept = in_valid && advance;

    // ------------------------------------------------------------------
    // Accept stage: decode, person validity and the memory read address.
    // ------------------------------------------------------------------
    logic                   slot_ok;
    logic                   joint_ok;
    logic                   sample_take;
    logic                   slot_valid;
    addr_t                  rd_addr;
    logic [MAX_PERSONS-1:0] person_valid_reg;
    logic [MAX_PERSONS-1:0] person_valid_next;

    assign slot_ok     = int'(person_slot) < MAX_PERSONS;
    assign joint_ok    = int'(joint_index) < JOINT_COUNT;
    assign sample_take = in_accept && slot_ok && joint_ok && (command == CMD_SAMPLE);
    assign rd_addr     = addr_t'(int'(person_slot) * JOINT_COUNT + int'(joint_index));

    always_comb
    begin
        slot_valid = 1'b0;
        for (int p = 0; p < MAX_PERSONS; p++)
        begin
            if (int'(person_slot) == p)
                slot_valid = person_valid_reg[p];
        end
    end

    // A sample sees the validity from before its own frame_last takes effect.
    always_comb
    begin
        person_valid_next = person_valid_reg;
        if (in_accept && slot_ok)
        begin
            case (command)
                CMD_SAMPLE:
                begin
                    for (int p = 0; p < MAX_PERSONS; p++)
                    begin
                        if (joint_ok && frame_last && int'(person_slot) == p)
                            person_valid_next[p] = 1'b1;
                    end
                end
                CMD_FORGET:
                begin
                    for (int p = 0; p < MAX_PERSONS; p++)
                    begin
                        if (int'(person_slot) == p)
                            person_valid_next[p] = 1'b0;
                    end
                end
                CMD_RESET_ALL:
                    person_valid_next = '0;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            person_valid_reg <= '0;
        else
            person_valid_reg <= person_valid_next;
    end

    // ------------------------------------------------------------------
    // State memories: moving averages and held classes, one entry per
    // person and joint. Written by the write-back stage, read at accept.
    // ------------------------------------------------------------------
    level_t avg_mem   [ENTRY_COUNT];
    class_t class_mem [ENTRY_COUNT];

    level_t mem_avg_reg;
    class_t mem_class_reg;

    logic   s2_valid_reg;
    addr_t  s2_addr_reg;
    level_t s2_avg_reg;
    class_t s2_class_next;
    logic   wr_en;

    assign wr_en = advance && s2_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            avg_mem[s2_addr_reg]   <= s2_avg_reg;
            class_mem[s2_addr_reg] <= s2_class_next;
        end
        if (advance)
        begin
            mem_avg_reg   <= avg_mem[rd_addr];
            mem_class_reg <= class_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the memory data is available. Forward from the write-back
    // stage and from the last write, then update the average.
    // ------------------------------------------------------------------
    logic   s1_valid_reg;
    addr_t  s1_addr_reg;
    level_t s1_sample_reg;
    logic   s1_first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= sample_take;
    end

    always_ff @(posedge clk)
    begin
        if (advance && sample_take)
        begin
            s1_addr_reg   <= rd_addr;
            s1_sample_reg <= level_t'(sample_level);
            s1_first_reg  <= !slot_valid;
        end
    end

    // Record of the most recent write, which the read issued in the same
    // cycle could not yet see.
    logic   wr_valid_reg;
    addr_t  wr_addr_reg;
    level_t wr_avg_reg;
    class_t wr_class_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_valid_reg <= 1'b0;
        else if (wr_en)
            wr_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wr_addr_reg  <= s2_addr_reg;
            wr_avg_reg   <= s2_avg_reg;
            wr_class_reg <= s2_class_next;
        end
    end

    logic                     hit_s2;
    logic                     hit_wr;
    level_t                   old_avg;
    class_t                   held_class;
    logic signed [LEVEL_BITS:0] level_diff;
    logic signed [LEVEL_BITS:0] gain_signed;
    logic signed [PROD_W-1:0] gain_product;
    logic [PROD_W-1:0]        avg_sum;
    level_t                   s2_avg_next;
    class_t                   s2_before_next;

    assign hit_s2 = s2_valid_reg && (s2_addr_reg == s1_addr_reg);
    assign hit_wr = wr_valid_reg && (wr_addr_reg == s1_addr_reg);

    always_comb
    begin
        if (hit_s2)
        begin
            old_avg    = s2_avg_reg;
            held_class = s2_class_next;
        end
        else if (hit_wr)
        begin
            old_avg    = wr_avg_reg;
            held_class = wr_class_reg;
        end
        else
        begin
            old_avg    = mem_avg_reg;
            held_class = mem_class_reg;
        end
    end

    // old*(1-g) + sample*g is computed as old + (sample-old)*g, so a single
    // signed multiplier does the work. The exact result stays in range.
    assign level_diff   = $signed({1'b0, s1_sample_reg}) - $signed({1'b0, old_avg});
    assign gain_signed  = $signed({1'b0, smoothing_gain_reg});
    assign gain_product = level_diff * gain_signed;
    assign avg_sum      = {2'b00, old_avg, {LEVEL_BITS{1'b0}}} + $unsigned(gain_product)
                          + ROUND_HALF;

    assign s2_avg_next    = s1_first_reg ? s1_sample_reg : avg_sum[2*LEVEL_BITS-1:LEVEL_BITS];
    assign s2_before_next = classify(old_avg, tracked_level_reg, inferred_level_reg);

    // ------------------------------------------------------------------
    // Stage 2: classify the new average, apply hysteresis, write back.
    // ------------------------------------------------------------------
    class_t s2_before_reg;
    class_t s2_held_reg;
    logic   s2_first_reg;
    class_t after_class;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_addr_reg   <= s1_addr_reg;
            s2_avg_reg    <= s2_avg_next;
            s2_before_reg <= s2_before_next;
            s2_held_reg   <= held_class;
            s2_first_reg  <= s1_first_reg;
        end
    end

    assign after_class = classify(s2_avg_reg, tracked_level_reg, inferred_level_reg);

    // The held class moves only when the old and the new average both
    // disagree with it; the first frame takes the new class outright.
    always_comb
    begin
        if (s2_first_reg)
            s2_class_next = after_class;
        else if ((after_class != s2_held_reg) && (s2_before_reg != s2_held_reg))
            s2_class_next = after_class;
        else
            s2_class_next = s2_held_reg;
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    class_t                   joint_class_reg;
    logic [FIELD_LEVEL_W-1:0] smoothed_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            joint_class_reg    <= s2_class_next;
            smoothed_level_reg <= FIELD_LEVEL_W'(s2_avg_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign joint_class    = joint_class_reg;
    assign smoothed_level = smoothed_level_reg;

endmodule

FILE: src/jvq_checker.sv
module jvq_checker
    import jvq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input command_t                 command,
    input logic                     out_valid,
    input logic                     out_stall,
    input class_t                   joint_class,
    input logic [FIELD_LEVEL_W-1:0] smoothed_level
);

    // The input is held back only while a result is waiting at a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the output is free");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(joint_class) && $stable(smoothed_level)))
        else $error("stalled result changed or vanished");

    // Forget, reset all and the unused code give no result; with the pipe
    // flowing, the output slot that they would have reached stays empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && command != CMD_SAMPLE) ##1 !in_stall ##1 !in_stall
            |=> !out_valid)
        else $error("result produced for a command that gives none");

    // Only defined classes leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (joint_class == CLASS_NOT_TRACKED || joint_class == CLASS_INFERRED
                       || joint_class == CLASS_TRACKED))
        else $error("undefined joint class on the output");

endmodule

bind joint_visibility_qualifier_core jvq_checker u_jvq_checker (.*);

FILE: tb/jvq_visibility_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the configuration port of the joint visibility
// qualifier. It keeps its own copy of the averages, classes and person
// validity, predicts each result and compares it with what the block returns.
module jvq_visibility_checker
    import jvq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    input  logic                     in_stall,
    input  command_t                 command,
    input  logic [SLOT_W-1:0]        person_slot,
    input  logic [JOINT_W-1:0]       joint_index,
    input  logic [FIELD_LEVEL_W-1:0] sample_level,
    input  logic                     frame_last,

    input  logic                     out_valid,
    input  logic                     out_stall,
    input  class_t                   joint_class,
    input  logic [FIELD_LEVEL_W-1:0] smoothed_level,

    input  logic                     cfg_write_en,
    input  cfg_index_t               cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,

    output int                       fail_count,
    output int                       pending_count,
    output int                       compared_count
);

    localparam int LW      = LEVEL_BITS_DEF;
    localparam int ENTRIES = MAX_PERSONS_DEF * JOINT_COUNT_DEF;

    typedef logic [LW-1:0] level_t;

    typedef struct packed {
        class_t cls;
        level_t level;
    } joint_outcome_t;

    joint_outcome_t awaited_q[$];

    level_t average_mem [ENTRIES];
    class_t class_mem   [ENTRIES];
    logic   person_live [MAX_PERSONS_DEF];

    level_t tracked_thr;
    level_t inferred_thr;
    level_t gain;

    function automatic class_t classify(input level_t level);
        if (level >= tracked_thr)
            return CLASS_TRACKED;
        if (level >= inferred_thr)
            return CLASS_INFERRED;
        return CLASS_NOT_TRACKED;
    endfunction

    // Moves the old average toward the sample by the gain, rounding half up.
    function automatic level_t blend(input level_t old_level, input level_t sample,
                                     input level_t g);
        logic [2*LW:0] acc;
        acc = old_level * ((2*LW+1)'(1) << LW) - old_level * g + sample * g
              + ((2*LW+1)'(1) << (LW - 1));
        return acc[2*LW-1:LW];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] check failed: %s", $time, what);
        fail_count++;
    endtask

    task automatic take_item();
        int     entry;
        level_t old_level;
        level_t new_level;
        class_t before_cls;
        class_t after_cls;
        class_t held_cls;
        class_t next_cls;
        case (command)
            CMD_SAMPLE:
            begin
                if (joint_index < JOINT_COUNT_DEF)
                begin
                    entry = int'(person_slot) * JOINT_COUNT_DEF + int'(joint_index);
                    if (!person_live[person_slot])
                    begin
                        new_level = sample_level;
                        next_cls  = classify(new_level);
                    end
                    else
                    begin
                        old_level  = average_mem[entry];
                        held_cls   = class_mem[entry];
                        before_cls = classify(old_level);
                        new_level  = blend(old_level, sample_level, gain);
                        after_cls  = classify(new_level);
                        next_cls   = (after_cls != held_cls && before_cls != held_cls) ?
                                     after_cls : held_cls;
                    end
                    average_mem[entry] = new_level;
                    class_mem[entry]   = next_cls;
                    if (frame_last)
                        person_live[person_slot] = 1'b1;
                    awaited_q.push_back('{cls: next_cls, level: new_level});
                end
            end
            CMD_FORGET:
            begin
                person_live[person_slot] = 1'b0;
            end
            CMD_RESET_ALL:
            begin
                foreach (person_live[p])
                    person_live[p] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        joint_outcome_t exp_item;
        if (!rst_n)
        begin
            awaited_q.delete();
            foreach (average_mem[e])
            begin
                average_mem[e] = '0;
                class_mem[e]   = CLASS_NOT_TRACKED;
            end
            foreach (person_live[p])
                person_live[p] = 1'b0;
            tracked_thr    = level_t'(TRACKED_LEVEL_RST);
            inferred_thr   = level_t'(INFERRED_LEVEL_RST);
            gain           = level_t'(SMOOTHING_GAIN_RST);
            fail_count     = 0;
            compared_count = 0;
            pending_count  = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_TRACKED_LEVEL:  tracked_thr  = cfg_data;
                    CFG_INFERRED_LEVEL: inferred_thr = cfg_data;
                    CFG_SMOOTHING_GAIN: gain         = cfg_data;
                    default:            ;
                endcase
            end
            if (in_valid && !in_stall)
                take_item();
            if (out_valid && !out_stall)
            begin
                if (awaited_q.size() == 0)
                    report_mismatch("result transfer with nothing awaited");
                else
                begin
                    exp_item = awaited_q.pop_front();
                    compared_count++;
                    if (joint_class !== exp_item.cls)
                        report_mismatch($sformatf("joint_class %0d, predicted %0d",
                                                  joint_class, exp_item.cls));
                    if (smoothed_level !== exp_item.level)
                        report_mismatch($sformatf("smoothed_level %0d, predicted %0d",
                                                  smoothed_level, exp_item.level));
                end
            end
            pending_count = awaited_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

// Top of the joint visibility qualifier testbench. This module only makes
// stimulus and gives the verdict; the checker beside the block watches every
// transfer, predicts the results and counts mismatches.
//
// The run is split into phases. Each phase has its own register setting and
// its own idling pattern on the two channels. Registers are only written once
// every awaited result has come back and the pipeline has had time to empty,
// since ignored items leave nothing to wait for.
module tb;
    import jvq_pkg::*;

    // The one command code that the package does not name; the block drops it.
    localparam command_t CMD_UNUSED = 2'd3;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 105;
    localparam int CYCLE_LIMIT  = 400000;
    // Extra wait after the drain so that dropped items have left the pipeline before registers change.
    localparam int DRAIN_CYCLES = 6;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    command_t                 command;
    logic [SLOT_W-1:0]        person_slot;
    logic [JOINT_W-1:0]       joint_index;
    logic [FIELD_LEVEL_W-1:0] sample_level;
    logic                     frame_last;
    logic                     out_valid;
    logic                     out_stall;
    class_t                   joint_class;
    logic [FIELD_LEVEL_W-1:0] smoothed_level;
    logic                     cfg_write_en;
    cfg_index_t               cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    int fail_count;
    int pending_count;
    int compared_count;

    // Register settings and idling per phase. Phase 0 keeps the reset values,
    // phase 4 draws its setting at random, and phase 5 inverts the thresholds.
    int unsigned tracked_tab  [PHASES] = '{32768, 65535, 0, 40000, 0, 1};
    int unsigned inferred_tab [PHASES] = '{19661, 0,     0, 20000, 0, 65535};
    int unsigned gain_tab     [PHASES] = '{26214, 65535, 0, 8192,  0, 1};
    int unsigned idle_tab     [PHASES] = '{0,     63,    0, 10,    0, 10};
    int unsigned stall_tab    [PHASES] = '{0,     0,     63, 10,   0, 10};

    int unsigned idle_pct;
    int unsigned stall_pct;
    logic [CFG_DATA_W-1:0] tracked_cfg;
    logic [CFG_DATA_W-1:0] inferred_cfg;

    // What the stimulus knows of the block's state, so that a valid person is
    // never sent a joint whose entry has not been written yet.
    bit person_live_seen [MAX_PERSONS_DEF];
    bit entry_written    [MAX_PERSONS_DEF][JOINT_COUNT_DEF];

    // Current frame of the random part.
    int                 frame_left;
    logic [SLOT_W-1:0]  frame_slot;
    logic [JOINT_W-1:0] prev_joint;
    bit                 prev_joint_ok;

    int sent_count;
    int useful_count;
    int cycle_count;

    joint_visibility_qualifier_core i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .person_slot    (person_slot),
        .joint_index    (joint_index),
        .sample_level   (sample_level),
        .frame_last     (frame_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .joint_class    (joint_class),
        .smoothed_level (smoothed_level),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    jvq_visibility_checker i_visibility_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .person_slot    (person_slot),
        .joint_index    (joint_index),
        .sample_level   (sample_level),
        .frame_last     (frame_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .joint_class    (joint_class),
        .smoothed_level (smoothed_level),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .compared_count (compared_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The receiver decides afresh at every falling edge whether to stall.
    initial out_stall = 1'b0;

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // A hung block must not hang the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results awaited.",
                     pending_count);
            $display("tb NOT OK");
            $finish;
        end
    end

    // Draws a visibility level. Half of the draws sit close to one of the two
    // thresholds so that the hysteresis is exercised, some are the extremes.
    function automatic logic [FIELD_LEVEL_W-1:0] pick_level();
        int unsigned r;
        int          v;
        r = $urandom_range(99);
        if (r < 10)
            v = $urandom_range(1) ? 65535 : 0;
        else if (r < 35)
            v = int'(tracked_cfg) + int'($urandom_range(64)) - 32;
        else if (r < 60)
            v = int'(inferred_cfg) + int'($urandom_range(64)) - 32;
        else
            v = $urandom_range(65535);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return FIELD_LEVEL_W'(v);
    endfunction

    // Offers one item on the input channel, with random idle cycles ahead of
    // it, and returns at the falling edge after the transfer. The payload is
    // held for as long as the block stalls.
    task automatic send_item(input command_t cmd, input logic [SLOT_W-1:0] slot,
                             input logic [JOINT_W-1:0] joint,
                             input logic [FIELD_LEVEL_W-1:0] level, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        person_slot  <= slot;
        joint_index  <= joint;
        sample_level <= level;
        frame_last   <= last;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        sent_count++;
    endtask

    // Keeps the stimulus-side view of validity and written entries in step
    // with the block, then sends the item.
    task automatic issue(input command_t cmd, input logic [SLOT_W-1:0] slot,
                         input logic [JOINT_W-1:0] joint,
                         input logic [FIELD_LEVEL_W-1:0] level, input logic last);
        case (cmd)
            CMD_SAMPLE:
            begin
                if (joint < JOINT_COUNT_DEF)
                begin
                    entry_written[slot][joint] = 1'b1;
                    if (last)
                        person_live_seen[slot] = 1'b1;
                    useful_count++;
                end
            end
            CMD_FORGET:
            begin
                person_live_seen[slot] = 1'b0;
                useful_count++;
            end
            CMD_RESET_ALL:
            begin
                foreach (person_live_seen[p])
                    person_live_seen[p] = 1'b0;
                useful_count++;
            end
            default:
            begin
            end
        endcase
        send_item(cmd, slot, joint, level, last);
    endtask

    // Writes all three registers on consecutive cycles. The block is idle.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] trk,
                                  input logic [CFG_DATA_W-1:0] inf,
                                  input logic [CFG_DATA_W-1:0] g);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_TRACKED_LEVEL;
        cfg_data     <= trk;
        @(negedge clk);
        cfg_index    <= CFG_INFERRED_LEVEL;
        cfg_data     <= inf;
        @(negedge clk);
        cfg_index    <= CFG_SMOOTHING_GAIN;
        cfg_data     <= g;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        tracked_cfg  = trk;
        inferred_cfg = inf;
    endtask

    // Holds the sender off until every awaited result has come back. The
    // first wait always passes a falling edge, so valid is never lowered and
    // raised again at the same edge.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Short hand-written sequence on the reset setting: every command, the
    // field extremes, the threshold edges and the hysteresis in both senses.
    task automatic directed_items();
        issue(CMD_RESET_ALL, 3'd0, 5'd0, 16'd0, 1'b1);
        issue(CMD_FORGET, 3'd7, 5'd31, 16'hFFFF, 1'b1);
        // First frame of person 0: each sample loads its average directly.
        issue(CMD_SAMPLE, 3'd0, 5'd0, 16'd0, 1'b0);
        issue(CMD_SAMPLE, 3'd0, 5'd1, 16'hFFFF, 1'b0);
        issue(CMD_SAMPLE, 3'd0, 5'd2, 16'd32768, 1'b0);
        issue(CMD_SAMPLE, 3'd0, 5'd3, 16'd32767, 1'b0);
        issue(CMD_SAMPLE, 3'd0, 5'd4, 16'd19661, 1'b0);
        issue(CMD_SAMPLE, 3'd0, 5'd5, 16'd19660, 1'b0);
        issue(CMD_SAMPLE, 3'd0, 5'd19, 16'd40000, 1'b1);
        // Joints beyond the table and the unused command are dropped.
        issue(CMD_SAMPLE, 3'd0, 5'd20, 16'd1234, 1'b1);
        issue(CMD_SAMPLE, 3'd0, 5'd31, 16'hFFFF, 1'b0);
        issue(CMD_UNUSED, 3'd7, 5'd31, 16'hFFFF, 1'b1);
        // Tracked joint driven to zero back to back: it holds through the
        // inferred band and only drops once both classes differ from it.
        issue(CMD_SAMPLE, 3'd0, 5'd1, 16'd0, 1'b0);
        issue(CMD_SAMPLE, 3'd0, 5'd1, 16'd0, 1'b0);
        issue(CMD_SAMPLE, 3'd0, 5'd1, 16'd0, 1'b0);
        // And the other way for a joint that started untracked.
        issue(CMD_SAMPLE, 3'd0, 5'd0, 16'hFFFF, 1'b0);
        issue(CMD_SAMPLE, 3'd0, 5'd0, 16'hFFFF, 1'b1);
        // After a forget the next frame loads again, then smooths.
        issue(CMD_FORGET, 3'd0, 5'd0, 16'd0, 1'b0);
        issue(CMD_SAMPLE, 3'd0, 5'd2, 16'd100, 1'b1);
        issue(CMD_SAMPLE, 3'd0, 5'd2, 16'd60000, 1'b1);
        // Highest slot and joint, then reset all and a fresh load.
        issue(CMD_SAMPLE, 3'd7, 5'd19, 16'hFFFF, 1'b1);
        issue(CMD_RESET_ALL, 3'd5, 5'd10, 16'd0, 1'b0);
        issue(CMD_SAMPLE, 3'd7, 5'd19, 16'd1, 1'b1);
    endtask

    // One random item. Most items belong to frames of random length for a
    // random person; the rest is noise: dropped items, forgets and resets.
    task automatic random_item();
        int unsigned        r;
        logic [JOINT_W-1:0] j;
        logic               last;
        r = $urandom_range(99);
        if (r < 5)
            issue(CMD_UNUSED, SLOT_W'($urandom_range(7)), JOINT_W'($urandom_range(31)),
                  pick_level(), ($urandom_range(1) != 0));
        else if (r < 10)
            issue(CMD_SAMPLE, SLOT_W'($urandom_range(7)),
                  JOINT_W'($urandom_range(31, JOINT_COUNT_DEF)),
                  pick_level(), ($urandom_range(1) != 0));
        else if (r < 14)
            issue(CMD_FORGET, SLOT_W'($urandom_range(7)), JOINT_W'($urandom_range(31)),
                  pick_level(), ($urandom_range(1) != 0));
        else if (r < 15)
            issue(CMD_RESET_ALL, SLOT_W'($urandom_range(7)), JOINT_W'($urandom_range(31)),
                  pick_level(), ($urandom_range(1) != 0));
        else
        begin
            if (frame_left == 0)
            begin
                frame_slot    = SLOT_W'($urandom_range(7));
                frame_left    = ($urandom_range(7) == 0) ? JOINT_COUNT_DEF :
                                $urandom_range(6, 1);
                prev_joint_ok = 1'b0;
            end
            // Repeating the last joint puts updates of one entry back to back.
            if (prev_joint_ok && $urandom_range(3) == 0)
                j = prev_joint;
            else if (person_live_seen[frame_slot])
            begin
                do
                    j = JOINT_W'($urandom_range(JOINT_COUNT_DEF - 1));
                while (!entry_written[frame_slot][j]);
            end
            else
                j = JOINT_W'($urandom_range(JOINT_COUNT_DEF - 1));
            last          = (frame_left == 1) || ($urandom_range(15) == 0);
            frame_left    = frame_left - 1;
            prev_joint    = j;
            prev_joint_ok = 1'b1;
            issue(CMD_SAMPLE, frame_slot, j, pick_level(), last);
        end
    endtask

    initial
    begin : stimulus
        int  target;
        bit  paused;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_SAMPLE;
        person_slot  = '0;
        joint_index  = '0;
        sample_level = '0;
        frame_last   = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_TRACKED_LEVEL;
        cfg_data     = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        tracked_cfg  = CFG_DATA_W'(TRACKED_LEVEL_RST);
        inferred_cfg = CFG_DATA_W'(INFERRED_LEVEL_RST);
        frame_left   = 0;
        paused       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_items();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                // Quiet the input, let every result come home, then change
                // the registers while nothing is in flight.
                hold_until_drained();
                repeat (DRAIN_CYCLES) @(negedge clk);
                if (p == 4)
                begin
                    inferred_tab[p] = $urandom_range(40000);
                    tracked_tab[p]  = $urandom_range(65535, inferred_tab[p]);
                    gain_tab[p]     = $urandom_range(65535);
                end
                apply_settings(CFG_DATA_W'(tracked_tab[p]), CFG_DATA_W'(inferred_tab[p]),
                               CFG_DATA_W'(gain_tab[p]));
            end
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            target    = useful_count + PHASE_ITEMS;
            while (useful_count < target)
            begin
                random_item();
                // Once in the run, the sender waits mid-phase for the block
                // to run completely dry before carrying on.
                if (p == 2 && !paused && useful_count >= target - PHASE_ITEMS / 2)
                begin
                    hold_until_drained();
                    paused = 1'b1;
                end
            end
        end

        in_valid <= 1'b0;
        idle_pct  = 0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (2 * DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d input transfers (%0d of them dropped by design) over %0d",
                 sent_count, sent_count - useful_count, PHASES);
        $display("register settings; %0d results compared, %0d mismatches.",
                 compared_count, fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
